>>> rtl/kmer_count_table_top_assert.svh
// Assertion macros for the k-mer count table.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KMER_COUNT_TABLE_TOP_ASSERT_SVH
`define KMER_COUNT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define KCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kct assertion failed");
`define KCT_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kct assertion failed");
`else
`define KCT_ASSERT(lbl, clk, rst_n, prop)
`define KCT_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

>>> rtl/kct_pkg.sv
// Shared types, constants and helper functions for the k-mer count table.
// Used by kct_fifo, kct_front, kct_back and kmer_count_table_top.
package kct_pkg;

    localparam int MAX_K      = 8;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = 2 * MAX_K;
    localparam int TOTAL_W    = 48;
    localparam int KEY_W      = 16;
    localparam int KLEN_W     = 4;
    localparam int SEEN_W     = 5;
    localparam int SEEN_MAX   = 31;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [1:0] MODE_INC  = 2'd0;
    localparam logic [1:0] MODE_DEC  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_KEY  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_LENGTH   = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [2:0] TY_INT8   = 3'd0;
    localparam logic [2:0] TY_UINT8  = 3'd1;
    localparam logic [2:0] TY_INT16  = 3'd2;
    localparam logic [2:0] TY_UINT16 = 3'd3;
    localparam logic [2:0] TY_INT32  = 3'd4;
    localparam logic [2:0] TY_UINT32 = 3'd5;
    localparam logic [2:0] TY_INT64  = 3'd6;
    localparam logic [2:0] TY_UINT64 = 3'd7;

    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_U = 8'h55;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] index;
        logic [7:0]  symbol;
        logic        last;
        logic        bump_total;
        logic [2:0]  out_type;
    } t_in;

    typedef struct packed {
        logic [31:0]        value;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total;
    } t_out;

    typedef enum logic [1:0] {
        OP_INC  = 2'd0,
        OP_DEC  = 2'd1,
        OP_READ = 2'd2,
        OP_STAT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic              bump;
        logic [2:0]        out_type;
        logic [1:0]        status;
    } t_op;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_sym;

    function automatic logic [SEEN_W-1:0] eff_k(input logic [KLEN_W-1:0] len);
        if (len == '0) return SEEN_W'(1);
        if (int'(len) > MAX_K) return SEEN_W'(MAX_K);
        return SEEN_W'(len);
    endfunction

    // index below 4^k and below the store depth
    function automatic logic in_range(input logic [KEY_W-1:0] idx,
                                      input logic [SEEN_W-1:0] k);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < KEY_W; i++) begin
            if ((i >= 2 * int'(k) || i >= ADDR_W) && idx[i]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic t_sym sym_decode(input logic [7:0] s);
        t_sym r;
        r.ok = 1'b1;
        case (s)
            CH_A: r.code = 2'd0;
            CH_C: r.code = 2'd1;
            CH_G: r.code = 2'd2;
            CH_T: r.code = 2'd3;
            CH_U: r.code = 2'd3;
            default: begin
                r.code = 2'd0;
                r.ok   = 1'b0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat_value(input logic [COUNT_BITS-1:0] v,
                                              input logic [2:0] t);
        logic [63:0] tmax;
        logic [63:0] v64;
        case (t)
            TY_INT8:   tmax = 64'h7F;
            TY_UINT8:  tmax = 64'hFF;
            TY_INT16:  tmax = 64'h7FFF;
            TY_UINT16: tmax = 64'hFFFF;
            TY_INT32:  tmax = 64'h7FFF_FFFF;
            TY_UINT32: tmax = 64'hFFFF_FFFF;
            TY_INT64:  tmax = 64'h7FFF_FFFF_FFFF_FFFF;
            TY_UINT64: tmax = 64'hFFFF_FFFF_FFFF_FFFF;
            default:   tmax = 64'hFFFF_FFFF;
        endcase
        v64 = 64'(v);
        if (v64 > tmax) v64 = tmax;
        if (v64 > 64'hFFFF_FFFF) v64 = 64'hFFFF_FFFF;
        return v64[31:0];
    endfunction

endpackage

>>> rtl/kct_fifo.sv
// Short operation queue between the front and back halves.
// Depends on kct_pkg for t_op and the queue depth.
module kct_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kct_pkg::t_op  i_push_op,
    output logic          o_full,
    output logic          o_valid,
    output kct_pkg::t_op  o_head,
    input  logic          i_pop
);
    import kct_pkg::*;

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = r_wr_ptr + 1'b1;
        if (i_pop) n_rd_ptr = r_rd_ptr + 1'b1;
        if (i_push && !i_pop) n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_op;
    end

endmodule

>>> rtl/kct_front.sv
// Front half: accepts words, holds k-mer length and key state, classifies ops.
// Depends on kct_pkg; feeds kct_fifo.
module kct_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  kct_pkg::t_in               i_in_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kct_pkg::KLEN_W-1:0] i_cfg_data,
    input  logic                       i_clearing,
    input  logic                       i_q_full,
    output logic                       o_push,
    output kct_pkg::t_op               o_push_op
);
    import kct_pkg::*;

    logic [KLEN_W-1:0] r_kmer_len;
    logic [KEY_W-1:0]  r_key_code, n_key_code;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_bad, n_bad;

    logic              accept;
    logic              push;
    logic [SEEN_W-1:0] k;
    t_sym              sym;
    logic [KEY_W-1:0]  code_upd;
    logic [SEEN_W-1:0] seen_upd;
    logic              bad_upd;
    t_op               op;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_clearing || i_q_full;
    assign accept      = i_in_valid && !o_in_stall;
    assign k           = eff_k(r_kmer_len);
    assign sym         = sym_decode(i_in_word.symbol);

    always_comb begin
        code_upd = sym.ok ? {r_key_code[KEY_W-3:0], sym.code} : r_key_code;
        bad_upd  = r_bad || !sym.ok;
        seen_upd = (r_seen != SEEN_W'(SEEN_MAX)) ? r_seen + 1'b1 : r_seen;

        n_key_code = r_key_code;
        n_seen     = r_seen;
        n_bad      = r_bad;
        push       = 1'b0;
        op.kind     = OP_STAT;
        op.addr     = ADDR_W'(i_in_word.index);
        op.bump     = i_in_word.bump_total;
        op.out_type = i_in_word.out_type;
        op.status   = ST_OK;

        case (i_in_word.mode)
            MODE_INC, MODE_DEC: begin
                push    = in_range(i_in_word.index, k);
                op.kind = (i_in_word.mode == MODE_INC) ? OP_INC : OP_DEC;
            end
            MODE_READ: begin
                push = 1'b1;
                if (in_range(i_in_word.index, k)) begin
                    op.kind = OP_READ;
                end else begin
                    op.status = ST_RANGE;
                end
            end
            MODE_KEY: begin
                n_key_code = code_upd;
                n_seen     = seen_upd;
                n_bad      = bad_upd;
                if (i_in_word.last) begin
                    push    = 1'b1;
                    op.addr = ADDR_W'(code_upd);
                    if (bad_upd) begin
                        op.status = ST_BAD_CHAR;
                    end else if (seen_upd != k) begin
                        op.status = ST_LENGTH;
                    end else if (in_range(code_upd, k)) begin
                        op.kind = OP_READ;
                    end else begin
                        op.status = ST_RANGE;
                    end
                    n_key_code = '0;
                    n_seen     = '0;
                    n_bad      = 1'b0;
                end
            end
            default: push = 1'b0;
        endcase
    end

    assign o_push    = accept && push;
    assign o_push_op = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= KLEN_W'(MAX_K);
            r_key_code <= '0;
            r_seen     <= '0;
            r_bad      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_kmer_len <= i_cfg_data;
            if (accept) begin
                r_key_code <= n_key_code;
                r_seen     <= n_seen;
                r_bad      <= n_bad;
            end
        end
    end

endmodule

>>> rtl/kct_back.sv
// Back half: counter memory with clearing pass, read-modify-write, total, result register.
// Depends on kct_pkg and kmer_count_table_top_assert.svh; fed by kct_fifo.
`include "kmer_count_table_top_assert.svh"

module kct_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  kct_pkg::t_op  i_q_head,
    output logic          o_q_pop,
    output logic          o_clearing,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kct_pkg::t_out o_out_word
);
    import kct_pkg::*;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } t_bstate;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

    logic [COUNT_BITS-1:0] mem [2**ADDR_W];

    t_bstate               r_state, n_state;
    logic [ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    t_op                   r_op;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out_word;

    logic                  out_free;
    logic                  is_rw;
    logic                  out_load;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] cnt_upd;
    t_out                  res;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_rw       = (r_op.kind == OP_INC) || (r_op.kind == OP_DEC);
    assign o_q_pop     = (r_state == B_IDLE) && i_q_valid;
    assign o_clearing  = (r_state == B_CLEAR);
    assign out_load    = (r_state == B_EXEC) && !is_rw && out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        cnt_upd = r_rd_data;
        n_total = r_total;
        if (r_op.kind == OP_INC) begin
            if (r_rd_data != COUNT_MAX) cnt_upd = r_rd_data + 1'b1;
            if (r_op.bump && r_total != TOTAL_MAX) n_total = r_total + 1'b1;
        end else if (r_op.kind == OP_DEC) begin
            if (r_rd_data != '0) cnt_upd = r_rd_data - 1'b1;
            if (r_op.bump && r_total != '0) n_total = r_total - 1'b1;
        end
        if (r_state != B_EXEC) n_total = r_total;

        wr_en   = 1'b0;
        wr_addr = r_op.addr;
        wr_data = cnt_upd;
        if (r_state == B_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (r_state == B_EXEC && is_rw) begin
            wr_en = 1'b1;
        end

        res.value  = (r_op.kind == OP_READ) ? sat_value(r_rd_data, r_op.out_type) : '0;
        res.status = r_op.status;
        res.total  = r_total;

        n_out_valid = r_out_valid;
        if (out_load) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;

        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            B_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (o_q_pop) n_state = B_EXEC;
            end
            B_EXEC: begin
                if (is_rw || out_free) n_state = B_IDLE;
            end
            default: n_state = B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (o_q_pop) begin
            r_rd_data <= mem[i_q_head.addr];
            r_op      <= i_q_head;
        end
        if (out_load) r_out_word <= res;
    end

    `KCT_ASSERT(a_no_pop_clear, i_clk, i_rst_n, (r_state == B_CLEAR) |-> !o_q_pop)
    `KCT_ASSERT(a_pop_to_exec, i_clk, i_rst_n, o_q_pop |=> (r_state == B_EXEC))
    `KCT_ASSERT(a_total_moves_in_exec, i_clk, i_rst_n, 1'b1 |=> ((r_total == $past(r_total)) || ($past(r_state) == B_EXEC)))
    `KCT_ASSERT_ANY(a_reset_clears, i_clk, !i_rst_n |=> (r_state == B_CLEAR))

endmodule

>>> rtl/kmer_count_table_top.sv
// Top level of the k-mer count table: front classifier, op queue, counter back end.
// Depends on kct_pkg, kct_front, kct_fifo and kct_back.
//
// After reset the block sweeps the 65536-entry counter memory to zero, one entry a
// cycle, and holds o_in_stall high throughout the sweep; the length register can
// be written meanwhile. The front takes one word a cycle while o_in_stall is low;
// key characters that are not last and out-of-range increments or decrements finish
// there. Every other word goes through a four-entry queue to the back end, which
// takes it in two steps (memory read on the pop in B_IDLE, then write-back or result
// load in B_EXEC) and pops no new word until it is back in B_IDLE, a limit set by the
// single read-modify-write port. A result leaves through a registered output and
// waits there only while i_out_stall holds; a second result behind it holds the back
// end, the queue fills and o_in_stall rises.
module kmer_count_table_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  kct_pkg::t_in               i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output kct_pkg::t_out              o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [kct_pkg::KLEN_W-1:0] i_cfg_data
);
    import kct_pkg::*;

    logic clearing;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_op  push_op;
    t_op  head_op;

    kct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_op   (push_op)
    );

    kct_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (head_op),
        .i_pop     (pop)
    );

    kct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head_op),
        .o_q_pop     (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
